FILE: rtl/core/lsps_pkg.sv
// Shared types, constants, pattern table and saturation for the line sensor PID steering block.
package lsps_pkg;

    localparam int SENSOR_COUNT = 14;
    localparam int SPEED_W      = 16;
    localparam int MODE_W       = 2;
    localparam int GAIN_W       = 16;
    localparam int ERR_W        = 5;
    localparam int DIFF_W       = 6;
    localparam int SUM_W        = 16;
    localparam int ACC_W        = 56;
    localparam int OUT_W        = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CNT_W        = 4;
    localparam int STEP_W       = 3;
    localparam int FRAC_SHIFT   = 8;
    localparam int ROUND_HALF   = 128;
    localparam int IN_W         = SENSOR_COUNT + SPEED_W + MODE_W;
    localparam int OUTDATA_W    = 3 * OUT_W;

    localparam logic [STEP_W-1:0] STEP_LAST     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SPEED_PD = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I        = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_SPEED_GAIN_P  = 3'd3,
        REG_SPEED_GAIN_D  = 3'd4,
        REG_SAMPLE_PERIOD = 3'd5,
        REG_SAMPLE_RATE   = 3'd6
    } cfg_reg_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_MUL  = 6'b000100,
        S_ADD  = 6'b001000,
        S_SUMS = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    typedef struct packed {
        logic                    known;
        logic signed [ERR_W-1:0] err;
    } lookup_t;

    function automatic lookup_t line_lookup(input logic [SENSOR_COUNT-1:0] pattern);
        lookup_t r;
        r.known = 1'b1;
        r.err   = 5'sd0;
        unique case (pattern)
            14'h0001: r.err = -5'sd15;
            14'h0003: r.err = -5'sd13;
            14'h0007: r.err = -5'sd11;
            14'h000F: r.err = -5'sd10;
            14'h001F: r.err = -5'sd9;
            14'h001E: r.err = -5'sd8;
            14'h003E: r.err = -5'sd7;
            14'h003C: r.err = -5'sd6;
            14'h007C: r.err = -5'sd5;
            14'h0078: r.err = -5'sd4;
            14'h00F8: r.err = -5'sd3;
            14'h00F0: r.err = -5'sd2;
            14'h01F0: r.err = -5'sd1;
            14'h01E0: r.err = 5'sd0;
            14'h03E0: r.err = 5'sd1;
            14'h03C0: r.err = 5'sd2;
            14'h07C0: r.err = 5'sd3;
            14'h0780: r.err = 5'sd4;
            14'h0F80: r.err = 5'sd5;
            14'h0F00: r.err = 5'sd6;
            14'h1F00: r.err = 5'sd7;
            14'h1E00: r.err = 5'sd8;
            14'h3E00: r.err = 5'sd9;
            14'h3C00: r.err = 5'sd10;
            14'h3800: r.err = 5'sd11;
            14'h3000: r.err = 5'sd13;
            14'h2000: r.err = 5'sd15;
            14'h01F8: r.err = -5'sd1;
            14'h03FC: r.err = -5'sd1;
            14'h07FE: r.err = -5'sd1;
            14'h03F0: r.err = 5'sd0;
            14'h07F8: r.err = 5'sd0;
            14'h0FFC: r.err = 5'sd0;
            14'h07E0: r.err = 5'sd1;
            14'h0FF0: r.err = 5'sd1;
            14'h1FF8: r.err = 5'sd1;
            14'h3E01: r.err = -5'sd2;
            14'h3801: r.err = -5'sd1;
            14'h3C03: r.err = -5'sd1;
            14'h2001: r.err = 5'sd0;
            14'h3003: r.err = 5'sd0;
            14'h3807: r.err = 5'sd0;
            14'h2007: r.err = -5'sd1;
            14'h300F: r.err = -5'sd1;
            14'h201F: r.err = -5'sd2;
            14'h30F0: r.err = -5'sd2;
            14'h21F0: r.err = -5'sd1;
            14'h21E1: r.err = 5'sd0;
            14'h03E1: r.err = 5'sd1;
            14'h23C3: r.err = 5'sd2;
            14'h38F0: r.err = -5'sd2;
            14'h20F0: r.err = -5'sd2;
            14'h39F0: r.err = -5'sd1;
            14'h31F0: r.err = -5'sd1;
            14'h39E0: r.err = 5'sd0;
            14'h31E0: r.err = 5'sd0;
            14'h21E0: r.err = 5'sd0;
            14'h3BE0: r.err = 5'sd1;
            14'h33E0: r.err = 5'sd1;
            14'h23E0: r.err = 5'sd1;
            14'h3BC0: r.err = 5'sd2;
            14'h33C0: r.err = 5'sd2;
            14'h23C0: r.err = 5'sd2;
            14'h27C0: r.err = 5'sd3;
            14'h2780: r.err = 5'sd4;
            14'h03C7: r.err = 5'sd2;
            14'h03C3: r.err = 5'sd2;
            14'h03C1: r.err = 5'sd2;
            14'h03E7: r.err = 5'sd1;
            14'h03E3: r.err = 5'sd1;
            14'h01E7: r.err = 5'sd0;
            14'h01E3: r.err = 5'sd0;
            14'h01E1: r.err = 5'sd0;
            14'h01F7: r.err = -5'sd1;
            14'h01F3: r.err = -5'sd1;
            14'h01F1: r.err = -5'sd1;
            14'h00F7: r.err = -5'sd2;
            14'h00F3: r.err = -5'sd2;
            14'h00F1: r.err = -5'sd2;
            14'h00F9: r.err = -5'sd3;
            14'h0079: r.err = -5'sd4;
            default:  r.known = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-OUT_W:0] upper;
        upper = x[ACC_W-1:OUT_W-1];
        if ((&upper) || !(|upper)) begin
            return x[OUT_W-1:0];
        end
        return x[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

endpackage

FILE: rtl/core/line_sensor_pid_steering.sv
// Line sensor PID steering controller with a bit-serial shift-add multiplier.
//
// One beat on s_axis carries a 14-bit sensor word, a Q8.8 base speed and a mode; once the
// product schedule is through, one beat on m_axis carries the saturated Q16.16 yaw
// correction and the left and right setpoints, with pattern_known on tuser. The work is
// done by the single shift-add multiplier, which takes one multiplier bit per cycle: five
// products are formed per beat (those against the error or its difference over the 6-bit
// difference width, those against the 16-bit integral, speed, period or rate over all 16
// bits), each framed by a load and an accumulate state; then the setpoint sums are formed
// and the result is registered. A new beat is taken only in idle; the result register lets
// the next beat start while the last result still waits. Configuration writes are taken
// in any cycle and must only be issued while the block is idle.
module line_sensor_pid_steering (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sensor_bits[13:0], base_speed[29:14], mode[31:30]
    input  logic [lsps_pkg::IN_W-1:0]           s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // yaw_rate[31:0], left_setpoint[63:32], right_setpoint[95:64]
    output logic [lsps_pkg::OUTDATA_W-1:0]      m_axis_tdata,
    // pattern_known[0]
    output logic                                m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsps_pkg::GAIN_W-1:0]         cfg_data
);

    localparam int ACC_W   = lsps_pkg::ACC_W;
    localparam int GAIN_W  = lsps_pkg::GAIN_W;
    localparam int ERR_W   = lsps_pkg::ERR_W;
    localparam int DIFF_W  = lsps_pkg::DIFF_W;
    localparam int SUM_W   = lsps_pkg::SUM_W;
    localparam int SPEED_W = lsps_pkg::SPEED_W;
    localparam int SENS_W  = lsps_pkg::SENSOR_COUNT;
    localparam int MODE_W  = lsps_pkg::MODE_W;
    localparam int CNT_W   = lsps_pkg::CNT_W;
    localparam int STEP_W  = lsps_pkg::STEP_W;
    localparam int SHIFT   = lsps_pkg::FRAC_SHIFT;

    lsps_pkg::state_t state_reg, state_next;

    logic [GAIN_W-1:0] gain_p_reg, gain_p_next;
    logic [GAIN_W-1:0] gain_i_reg, gain_i_next;
    logic [GAIN_W-1:0] gain_d_reg, gain_d_next;
    logic [GAIN_W-1:0] speed_gain_p_reg, speed_gain_p_next;
    logic [GAIN_W-1:0] speed_gain_d_reg, speed_gain_d_next;
    logic [GAIN_W-1:0] sample_period_reg, sample_period_next;
    logic [GAIN_W-1:0] sample_rate_reg, sample_rate_next;

    logic signed [ERR_W-1:0]   prev_err_reg, prev_err_next;
    logic [SUM_W-1:0]          err_sum_reg, err_sum_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic signed [SPEED_W-1:0] speed_reg, speed_next;
    logic                      pd_reg, pd_next;
    logic                      known_reg, known_next;

    logic [STEP_W-1:0]         step_reg, step_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [ACC_W-1:0]   a_reg, a_next;
    logic [GAIN_W-1:0]         b_reg, b_next;
    logic                      bsig_reg, bsig_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   sum_reg, sum_next;
    logic signed [ACC_W-1:0]   left_reg, left_next;
    logic signed [ACC_W-1:0]   right_reg, right_next;

    logic                               out_valid_reg, out_valid_next;
    logic [lsps_pkg::OUTDATA_W-1:0]     out_data_reg, out_data_next;
    logic                               out_known_reg, out_known_next;

    logic [SENS_W-1:0]          in_bits;
    logic [SPEED_W-1:0]         in_speed;
    logic [MODE_W-1:0]          in_mode;
    logic [SENS_W-1:0]          in_pattern;
    lsps_pkg::lookup_t          lk;
    logic signed [ERR_W-1:0]    e_new;
    logic                       in_fire;
    logic                       out_free;

    logic signed [ACC_W-1:0]    a_load;
    logic [GAIN_W-1:0]          b_load;
    logic [CNT_W-1:0]           n_load;
    logic                       bsig_load;
    logic signed [ACC_W-1:0]    acc_init;
    logic signed [ACC_W-1:0]    term;
    logic signed [ACC_W-1:0]    addend;
    logic signed [ACC_W-1:0]    speed_wide;
    logic [GAIN_W-1:0]          err_ext;
    logic [GAIN_W-1:0]          diff_ext;

    assign s_axis_tready = (state_reg == lsps_pkg::S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_known_reg;

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign in_bits    = s_axis_tdata[SENS_W-1:0];
    assign in_speed   = s_axis_tdata[SENS_W+SPEED_W-1:SENS_W];
    assign in_mode    = s_axis_tdata[SENS_W+SPEED_W+MODE_W-1:SENS_W+SPEED_W];
    assign in_pattern = in_mode[0] ? ~in_bits : in_bits;
    assign lk         = lsps_pkg::line_lookup(in_pattern);
    assign e_new      = lk.known ? lk.err : prev_err_reg;

    assign err_ext    = {{(GAIN_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
    assign diff_ext   = {{(GAIN_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
    assign speed_wide = ACC_W'(speed_reg);

    // Operand selection for each product of the schedule
    always_comb
    begin
        a_load    = '0;
        b_load    = '0;
        n_load    = CNT_W'(GAIN_W - 1);
        bsig_load = 1'b0;
        acc_init  = '0;
        if (pd_reg)
        begin
            unique case (step_reg)
                3'd0:
                begin
                    a_load    = signed'(ACC_W'(speed_gain_p_reg));
                    b_load    = err_ext;
                    n_load    = CNT_W'(DIFF_W - 1);
                    bsig_load = 1'b1;
                end
                3'd1:
                begin
                    a_load    = acc_reg;
                    b_load    = speed_reg;
                    bsig_load = 1'b1;
                end
                3'd2:
                begin
                    a_load    = signed'(ACC_W'(speed_gain_d_reg));
                    b_load    = diff_ext;
                    n_load    = CNT_W'(DIFF_W - 1);
                    bsig_load = 1'b1;
                end
                3'd3:
                begin
                    a_load    = acc_reg;
                    b_load    = sample_rate_reg;
                end
                default:
                begin
                    a_load    = acc_reg;
                    b_load    = speed_reg;
                    bsig_load = 1'b1;
                end
            endcase
        end
        else
        begin
            unique case (step_reg)
                3'd0:
                begin
                    a_load    = signed'(ACC_W'(gain_p_reg));
                    b_load    = err_ext;
                    n_load    = CNT_W'(DIFF_W - 1);
                    bsig_load = 1'b1;
                end
                3'd1:
                begin
                    a_load    = signed'(ACC_W'(gain_i_reg));
                    b_load    = err_sum_reg;
                    bsig_load = 1'b1;
                end
                3'd2:
                begin
                    a_load    = acc_reg;
                    b_load    = sample_period_reg;
                    acc_init  = signed'(ACC_W'(lsps_pkg::ROUND_HALF));
                end
                3'd3:
                begin
                    a_load    = signed'(ACC_W'(gain_d_reg));
                    b_load    = diff_ext;
                    n_load    = CNT_W'(DIFF_W - 1);
                    bsig_load = 1'b1;
                end
                default:
                begin
                    a_load    = acc_reg;
                    b_load    = sample_rate_reg;
                end
            endcase
        end
    end

    // Contribution of the finished product to the running sum
    always_comb
    begin
        term = '0;
        if (pd_reg)
        begin
            if (step_reg == 3'd1 || step_reg == lsps_pkg::STEP_LAST)
            begin
                term = acc_reg;
            end
        end
        else
        begin
            unique case (step_reg)
                3'd0:    term = acc_reg <<< SHIFT;
                3'd2:    term = acc_reg >>> SHIFT;
                3'd4:    term = acc_reg <<< SHIFT;
                default: term = '0;
            endcase
        end
    end

    assign addend = b_reg[0] ? a_reg : '0;

    always_comb
    begin
        state_next         = state_reg;
        gain_p_next        = gain_p_reg;
        gain_i_next        = gain_i_reg;
        gain_d_next        = gain_d_reg;
        speed_gain_p_next  = speed_gain_p_reg;
        speed_gain_d_next  = speed_gain_d_reg;
        sample_period_next = sample_period_reg;
        sample_rate_next   = sample_rate_reg;
        prev_err_next      = prev_err_reg;
        err_sum_next       = err_sum_reg;
        err_next           = err_reg;
        diff_next          = diff_reg;
        speed_next         = speed_reg;
        pd_next            = pd_reg;
        known_next         = known_reg;
        step_next          = step_reg;
        cnt_next           = cnt_reg;
        a_next             = a_reg;
        b_next             = b_reg;
        bsig_next          = bsig_reg;
        acc_next           = acc_reg;
        sum_next           = sum_reg;
        left_next          = left_reg;
        right_next         = right_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;
        out_known_next     = out_known_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lsps_pkg::REG_GAIN_P:        gain_p_next        = cfg_data;
                lsps_pkg::REG_GAIN_I:        gain_i_next        = cfg_data;
                lsps_pkg::REG_GAIN_D:        gain_d_next        = cfg_data;
                lsps_pkg::REG_SPEED_GAIN_P:  speed_gain_p_next  = cfg_data;
                lsps_pkg::REG_SPEED_GAIN_D:  speed_gain_d_next  = cfg_data;
                lsps_pkg::REG_SAMPLE_PERIOD: sample_period_next = cfg_data;
                lsps_pkg::REG_SAMPLE_RATE:   sample_rate_next   = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            lsps_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    err_next      = e_new;
                    diff_next     = DIFF_W'(e_new) - DIFF_W'(prev_err_reg);
                    known_next    = lk.known;
                    speed_next    = in_speed;
                    pd_next       = (in_mode == lsps_pkg::MODE_SPEED_PD);
                    prev_err_next = e_new;
                    err_sum_next  = err_sum_reg + SUM_W'(e_new);
                    sum_next      = '0;
                    step_next     = '0;
                    state_next    = lsps_pkg::S_LOAD;
                end
            end
            lsps_pkg::S_LOAD:
            begin
                a_next     = a_load;
                b_next     = b_load;
                cnt_next   = n_load;
                bsig_next  = bsig_load;
                acc_next   = acc_init;
                state_next = lsps_pkg::S_MUL;
            end
            lsps_pkg::S_MUL:
            begin
                // subtract the top bit's weight of a signed multiplier
                if (cnt_reg == '0 && bsig_reg)
                begin
                    acc_next = acc_reg - addend;
                end
                else
                begin
                    acc_next = acc_reg + addend;
                end
                a_next   = a_reg <<< 1;
                b_next   = b_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = lsps_pkg::S_ADD;
                end
            end
            lsps_pkg::S_ADD:
            begin
                sum_next = sum_reg + term;
                if (step_reg == lsps_pkg::STEP_LAST)
                begin
                    state_next = lsps_pkg::S_SUMS;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = lsps_pkg::S_LOAD;
                end
            end
            lsps_pkg::S_SUMS:
            begin
                left_next  = (speed_wide <<< SHIFT) + sum_reg;
                right_next = (speed_wide <<< SHIFT) - sum_reg;
                state_next = lsps_pkg::S_DONE;
            end
            lsps_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_data_next  = {lsps_pkg::sat_out(right_reg),
                                      lsps_pkg::sat_out(left_reg),
                                      lsps_pkg::sat_out(sum_reg)};
                    out_known_next = known_reg;
                    out_valid_next = 1'b1;
                    state_next     = lsps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lsps_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= lsps_pkg::S_IDLE;
            gain_p_reg        <= 16'd512;
            gain_i_reg        <= 16'd3840;
            gain_d_reg        <= 16'd0;
            speed_gain_p_reg  <= 16'd0;
            speed_gain_d_reg  <= 16'd0;
            sample_period_reg <= 16'd66;
            sample_rate_reg   <= 16'd1000;
            prev_err_reg      <= '0;
            err_sum_reg       <= '0;
            out_valid_reg     <= 1'b0;
            step_reg          <= '0;
            cnt_reg           <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            gain_p_reg        <= gain_p_next;
            gain_i_reg        <= gain_i_next;
            gain_d_reg        <= gain_d_next;
            speed_gain_p_reg  <= speed_gain_p_next;
            speed_gain_d_reg  <= speed_gain_d_next;
            sample_period_reg <= sample_period_next;
            sample_rate_reg   <= sample_rate_next;
            prev_err_reg      <= prev_err_next;
            err_sum_reg       <= err_sum_next;
            out_valid_reg     <= out_valid_next;
            step_reg          <= step_next;
            cnt_reg           <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg       <= err_next;
        diff_reg      <= diff_next;
        speed_reg     <= speed_next;
        pd_reg        <= pd_next;
        known_reg     <= known_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        bsig_reg      <= bsig_next;
        acc_reg       <= acc_next;
        sum_reg       <= sum_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        out_data_reg  <= out_data_next;
        out_known_reg <= out_known_next;
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == lsps_pkg::S_LOAD) && (step_reg == '0))
        else $error("accepted beat did not start the product schedule");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= lsps_pkg::STEP_LAST)
        else $error("step counter beyond last product");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == lsps_pkg::S_DONE))
        else $error("result raised outside the done state");

    a_unknown_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !lk.known) |=> $stable(prev_err_reg))
        else $error("unknown pattern changed the held error");

endmodule
